/* hdl/drt_pkg.sv */
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types, constants and compact-target decoding for the retarget unit.
// ----------------------------------------------------------------------------
`default_nettype none
package drt_pkg;

    localparam int TARGET_BITS  = 256;
    localparam int LIMB_W       = 32;
    localparam int LIMBS        = TARGET_BITS / LIMB_W;
    localparam int TBYTES       = TARGET_BITS / 8;
    localparam int DIV_RADIX_W  = 4;
    localparam int DIV_STEPS    = TARGET_BITS / DIV_RADIX_W;
    localparam int SPAN_W       = 33;
    localparam int TSPAN_W      = 31;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DS_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMESPAN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POW_LIMIT = 2'd2;

    localparam logic               RST_DS_ENABLE = 1'b1;
    localparam logic [TSPAN_W-1:0] RST_TIMESPAN  = 31'd60;
    localparam logic [31:0]        RST_POW_LIMIT = 32'h1e0f_ffff;

    localparam logic [31:0] HEIGHT_HIGH = 32'd10000;
    localparam logic [31:0] HEIGHT_MID  = 32'd5000;

    typedef struct packed {
        logic [SPAN_W-1:0] span;
        logic [31:0]       bits;
    } t_item;

    function automatic logic [TARGET_BITS-1:0] decode_compact(input logic [31:0] c);
        logic [7:0]             size;
        logic [TARGET_BITS-1:0] m;
        logic [10:0]            sh;
        m = {{(TARGET_BITS-23){1'b0}}, c[22:0]};
        size = c[31:24];
        if (size <= 8'd3) begin
            sh = {3'b0, (8'd3 - size)} << 3;
            decode_compact = m >> sh;
        end else begin
            sh = {3'b0, (size - 8'd3)} << 3;
            decode_compact = m << sh;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/drt_front.sv */
// ----------------------------------------------------------------------------
// drt_front
// Accepts items, computes the span (damped when DS is enabled, actual otherwise), clamps it, registers the result.
// ----------------------------------------------------------------------------
`default_nettype none
module drt_front import drt_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_ds_enable,
    input  wire  [TSPAN_W-1:0] i_timespan,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [30:0]        i_last_height,
    input  wire  [31:0]        i_last_time,
    input  wire  [31:0]        i_first_time,
    input  wire  [31:0]        i_last_bits,
    output logic               o_valid,
    input  wire                i_ready,
    output t_item              o_item
);

    logic        r_valid;
    t_item       r_item;
    logic signed [35:0] w_t, w_act, w_d, w_dq, w_span, w_lo, w_hi, w_cl;
    logic [31:0] w_nh;

    always_comb begin
        w_t   = {5'b0, i_timespan};
        w_act = $signed({4'b0, i_last_time}) - $signed({4'b0, i_first_time});
        w_d   = w_act - w_t;
        w_dq  = (w_d < 0) ? ((w_d + 36'sd7) >>> 3) : (w_d >>> 3);
        w_nh  = {1'b0, i_last_height} + 32'd1;
        if (i_ds_enable) begin
            w_span = w_t + w_dq;
            w_lo   = w_t - (w_t >>> 2);
            w_hi   = w_t + (w_t >>> 1);
        end else begin
            w_span = w_act;
            if (w_nh > HEIGHT_HIGH)
                w_lo = w_t >>> 2;
            else if (w_nh > HEIGHT_MID)
                w_lo = w_t >>> 3;
            else
                w_lo = w_t >>> 4;
            w_hi = w_t <<< 2;
        end
        if (w_span < w_lo)
            w_cl = w_lo;
        else if (w_span > w_hi)
            w_cl = w_hi;
        else
            w_cl = w_span;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item.span <= w_cl[SPAN_W-1:0];
            r_item.bits <= i_last_bits;
        end
    end

endmodule
`default_nettype wire

/* hdl/drt_queue.sv */
// ----------------------------------------------------------------------------
// drt_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module drt_queue import drt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  wire   i_ready,
    output t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_count;
    logic           w_push, w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push)
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (w_pop)
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            if (w_push && !w_pop)
                r_count <= r_count + 1'b1;
            else if (w_pop && !w_push)
                r_count <= r_count - 1'b1;
        end
        if (w_push)
            r_mem[r_wptr] <= i_item;
    end

endmodule
`default_nettype wire

/* hdl/drt_back.sv */
// ----------------------------------------------------------------------------
// drt_back
// Sequencer: limb multiply, radix-16 division, cap, compact re-encode.
// ----------------------------------------------------------------------------
`default_nettype none
module drt_back import drt_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [TSPAN_W-1:0] i_timespan,
    input  wire  [31:0]        i_pow_limit,
    input  wire                i_valid,
    output logic               o_ready,
    input  t_item              i_item,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [31:0]        o_next_bits
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_SIZE = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int SZ_W  = $clog2(TBYTES + 1);

    logic [2:0]             r_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [TARGET_BITS-1:0] r_a, r_p;
    logic [SPAN_W-1:0]      r_s, r_carry;
    logic [31:0]            r_rem;
    logic [TBYTES-1:0]      r_nz;
    logic [SZ_W-1:0]        r_size;
    logic                   r_out_valid;
    logic [31:0]            r_out_bits;

    logic [64:0]            w_prod;
    logic [31:0]            w_rem;
    logic [DIV_RADIX_W-1:0] w_qbits;
    logic [TARGET_BITS-1:0] w_lim;
    logic [SZ_W-1:0]        w_size;
    logic [7:0]             w_esize;
    logic [23:0]            w_comp;
    logic [TARGET_BITS-1:0] w_sh;
    logic                   w_emit;

    assign w_prod = r_a[LIMB_W-1:0] * r_s + {32'b0, r_carry};
    assign w_lim  = decode_compact(i_pow_limit);

    always_comb begin
        w_rem = r_rem;
        for (int k = 0; k < DIV_RADIX_W; k++) begin
            w_rem = {w_rem[30:0], r_p[TARGET_BITS-1-k]};
            w_qbits[DIV_RADIX_W-1-k] = (w_rem >= {1'b0, i_timespan});
            if (w_qbits[DIV_RADIX_W-1-k])
                w_rem = w_rem - {1'b0, i_timespan};
        end
    end

    always_comb begin
        w_size = '0;
        for (int j = 0; j < TBYTES; j++)
            if (r_nz[j])
                w_size = SZ_W'(j + 1);
    end

    always_comb begin
        w_esize = {{(8-SZ_W){1'b0}}, r_size};
        if (r_size <= SZ_W'(3)) begin
            w_sh   = r_p << {(8'd3 - w_esize), 3'b0};
        end else begin
            w_sh   = r_p >> {(w_esize - 8'd3), 3'b0};
        end
        w_comp = w_sh[23:0];
        if (w_comp[23]) begin
            w_comp  = w_comp >> 8;
            w_esize = w_esize + 8'd1;
        end
    end

    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || i_ready);
    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_next_bits = r_out_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !w_emit)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_state <= S_MUL;
                    r_cnt   <= '0;
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(LIMBS - 1)) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1))
                        r_state <= S_CMP;
                end
                S_CMP:  r_state <= S_SCAN;
                S_SCAN: r_state <= S_SIZE;
                S_SIZE: r_state <= S_EMIT;
                S_EMIT: if (w_emit) begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
        unique case (r_state)
            S_IDLE: begin
                r_a     <= decode_compact(i_item.bits);
                r_s     <= i_item.span;
                r_carry <= '0;
                r_rem   <= '0;
            end
            S_MUL: begin
                r_p     <= {w_prod[LIMB_W-1:0], r_p[TARGET_BITS-1:LIMB_W]};
                r_a     <= r_a >> LIMB_W;
                r_carry <= w_prod[64:LIMB_W];
            end
            S_DIV: begin
                r_p   <= {r_p[TARGET_BITS-1-DIV_RADIX_W:0], w_qbits};
                r_rem <= w_rem;
            end
            S_CMP: if (r_p > w_lim)
                r_p <= w_lim;
            S_SCAN: for (int j = 0; j < TBYTES; j++)
                r_nz[j] <= |r_p[8*j +: 8];
            S_SIZE: r_size <= w_size;
            S_EMIT: if (w_emit)
                r_out_bits <= {w_esize, w_comp};
            default: ;
        endcase
    end

    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> r_cnt < CNT_W'(LIMBS))
        else $error("multiply ran past the last limb");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> r_state == S_MUL)
        else $error("accepted item did not start the multiply");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented after emit");
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_size <= SZ_W'(TBYTES))
        else $error("byte length out of range");

endmodule
`default_nettype wire

/* hdl/difficulty_retarget_unit.sv */
// ----------------------------------------------------------------------------
// difficulty_retarget_unit
// Timespan clamp, 256-bit target scale by span over timespan, limit cap.
// ----------------------------------------------------------------------------
// Path: front register, queue, back load, limb multiply, divide at four
// quotient bits a cycle, cap and encode (compare, byte scan, size, emit).
// The back sequence takes one item at a time and accepts the next only once
// its result is emitted and it is idle again; the queue lets input run ahead.
// Reset: synchronous active-low; clears control state, loads register defaults.
`default_nettype none
module difficulty_retarget_unit import drt_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // last_height[30:0], last_time[62:31], first_time[94:63], last_bits[126:95]
    input  wire  [127:0]         s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // next_bits[31:0]
    output logic [31:0]          m_axis_tdata
);

    logic               r_ds_enable;
    logic [TSPAN_W-1:0] r_timespan;
    logic [31:0]        r_pow_limit;

    logic  f_valid, f_ready, q_valid, q_ready;
    t_item f_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds_enable <= RST_DS_ENABLE;
            r_timespan  <= RST_TIMESPAN;
            r_pow_limit <= RST_POW_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DS_ENABLE: r_ds_enable <= i_cfg_wr_data[0];
                CFG_TIMESPAN:  r_timespan  <= i_cfg_wr_data[TSPAN_W-1:0];
                CFG_POW_LIMIT: r_pow_limit <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    drt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ds_enable   (r_ds_enable),
        .i_timespan    (r_timespan),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_last_height (s_axis_tdata[30:0]),
        .i_last_time   (s_axis_tdata[62:31]),
        .i_first_time  (s_axis_tdata[94:63]),
        .i_last_bits   (s_axis_tdata[126:95]),
        .o_valid       (f_valid),
        .i_ready       (f_ready),
        .o_item        (f_item)
    );

    drt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    drt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timespan  (r_timespan),
        .i_pow_limit (r_pow_limit),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_item      (q_item),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_next_bits (m_axis_tdata)
    );

endmodule
`default_nettype wire
